### design/lptpc_pkg.sv
// package for the link power controller: register indexes, mode codes, widths
// no dependencies
`default_nettype none
package lptpc_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegPrrTarget = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainProp = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainInteg = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPowerFloor = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPowerCeiling = 3'd4;
  localparam logic [1:0] ModeReport = 2'd0;
  localparam logic [1:0] ModeForget = 2'd1;
  localparam logic [1:0] ModeTick = 2'd2;
  localparam int unsigned MaxOut = 16;

  typedef struct packed {
    logic [6:0] prr_target;
    logic [15:0] gain_prop;
    logic [15:0] gain_integ;
    logic [4:0] power_floor;
    logic [4:0] power_ceiling;
  } cfg_t;

  // serial divider handshake
  typedef struct packed {
    logic start;
    logic [14:0] dividend;
    logic [7:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [14:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

### design/lptpc_div.sv
// restoring radix-2 divider, one quotient bit per cycle
// depends on lptpc_pkg
`default_nettype none
module lptpc_div (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lptpc_pkg::div_req_t  req_i,
  output lptpc_pkg::div_rsp_t       rsp_o
);
  logic [14:0] quo_q, quo_d;
  logic [8:0] rem_q, rem_d;
  logic [7:0] dvs_q, dvs_d;
  logic [3:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [8:0] trial;
  logic [9:0] diff;

  always_comb begin
    trial = {rem_q[7:0], quo_q[14]};
    diff = {1'b0, trial} - {2'b0, dvs_q};
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = 4'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[9]) begin
        rem_d = diff[8:0];
      end else begin
        rem_d = trial;
      end
      quo_d = {quo_q[13:0], ~diff[9]};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd14) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

### design/lptpc_mac.sv
// serial multiply-accumulate: 16-bit unsigned gain times signed multiplier,
// one gain bit per cycle; depends on nothing
`default_nettype none
module lptpc_mac (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               clear_i,
  input  wire logic [15:0]        gain_i,
  input  wire logic signed [19:0] mult_i,
  output logic                    done_o,
  output logic signed [39:0]      acc_o
);
  logic [15:0] gain_q;
  logic signed [39:0] addend_q;
  logic signed [39:0] acc_q;
  logic [4:0] cnt_q;
  logic busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == 5'd15);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd15) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      acc_q <= '0;
    end
    if (start_i) begin
      gain_q <= gain_i;
      addend_q <= 40'(mult_i);
    end else if (busy_q) begin
      if (gain_q[0]) begin
        acc_q <= acc_q + addend_q;
      end
      gain_q <= {1'b0, gain_q[15:1]};
      addend_q <= addend_q <<< 1;
    end
  end

  assign done_o = done_q;
  assign acc_o = acc_q;
endmodule
`default_nettype wire

### design/link_pi_tx_power_controller.sv
// link transmit power controller, top level
// depends on lptpc_pkg, lptpc_div, lptpc_mac
// report and forget: busy for one cycle, result beat in the cycle after; no new item while busy
// tick: read, check, two serial divisions, three serial multiply passes, emit per updated slot,
// read, check, emit otherwise; one result per slot, only the first 16 slots emit
// results cannot be stalled; reset clears slot valid bits and loads register defaults
`default_nettype none
module link_pi_tx_power_controller #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           cfg_we_i,
  input  wire logic [lptpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [lptpc_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic [1:0]                     mode_i,
  input  wire logic [3:0]                     slot_i,
  input  wire logic [4:0]                     tx_power_i,
  input  wire logic [6:0]                     attempts_i,
  input  wire logic                           delivered_i,
  output logic                                strobe,
  output logic                                kind_o,
  output logic [3:0]                          out_slot_o,
  output logic [4:0]                          power_o,
  output logic                                slot_known_o,
  output logic                                updated_o,
  output logic                                last_o
);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NOut = (SLOTS < lptpc_pkg::MaxOut) ? SLOTS : lptpc_pkg::MaxOut;

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StRep   = 10'b0000000010,
    StTRd   = 10'b0000000100,
    StTChk  = 10'b0000001000,
    StDiv   = 10'b0000010000,
    StGdiv  = 10'b0000100000,
    StMac1  = 10'b0001000000,
    StMac2  = 10'b0010000000,
    StMac3  = 10'b0100000000,
    StEmit  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  lptpc_pkg::cfg_t cfg_q;

  // slot store: valid bits in flops, the rest in a memory
  logic [SLOTS-1:0] valid_q;
  logic [4:0] pw_mem [SLOTS];
  logic [6:0] prv_mem [SLOTS];
  logic [15:0] off_mem [SLOTS];
  logic [7:0] dlv_mem [SLOTS];
  logic [7:0] att_mem [SLOTS];

  logic [4:0] pw_r;
  logic [6:0] prv_r;
  logic signed [15:0] off_r;
  logic [7:0] dlv_r, att_r;

  // item latch
  logic [1:0] mode_q;
  logic [3:0] slot_q;
  logic [4:0] txp_q;
  logic [6:0] att_in_q;
  logic dlv_in_q;
  logic [SW:0] idx_q;
  logic [6:0] rate_q;
  logic [6:0] g_q;
  logic upd_q;

  // result registers
  logic strobe_q, kind_q, known_q, updq_q, last_q;
  logic [3:0] oslot_q;
  logic [4:0] opw_q;

  logic in_range;
  logic [SW-1:0] sidx;
  logic [SW-1:0] tidx;
  logic max_code;
  logic wr_en;
  logic [4:0] wr_pw;
  logic [6:0] wr_prv;
  logic [15:0] wr_off;
  logic [7:0] wr_dlv, wr_att;
  logic [SW-1:0] wr_idx;
  logic [SW-1:0] rd_idx;

  lptpc_pkg::div_req_t div_req;
  lptpc_pkg::div_rsp_t div_rsp;
  logic mac_start, mac_clear, mac_done;
  logic [15:0] mac_gain;
  logic signed [19:0] mac_mult;
  logic signed [39:0] mac_acc;

  lptpc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  lptpc_mac u_mac (.clk_i, .rst_ni, .start_i(mac_start), .clear_i(mac_clear),
                   .gain_i(mac_gain), .mult_i(mac_mult), .done_o(mac_done),
                   .acc_o(mac_acc));

  assign busy = (state_q != StIdle);
  assign in_range = ({4'b0, slot_q} < 8'(SLOTS)) || (SLOTS > 16);
  assign sidx = SW'(slot_q);
  assign tidx = idx_q[SW-1:0];
  assign max_code = (txp_q == 5'd0) || (txp_q == 5'd30) || (txp_q == 5'd31);
  assign rd_idx = (state_q == StIdle) ? SW'(slot_i) : ((state_q == StRep) ? sidx : tidx);

  // registered read of the slot memory
  always_ff @(posedge clk_i) begin
    pw_r <= pw_mem[rd_idx];
    prv_r <= prv_mem[rd_idx];
    off_r <= off_mem[rd_idx];
    dlv_r <= dlv_mem[rd_idx];
    att_r <= att_mem[rd_idx];
    if (wr_en) begin
      pw_mem[wr_idx] <= wr_pw;
      prv_mem[wr_idx] <= wr_prv;
      off_mem[wr_idx] <= wr_off;
      dlv_mem[wr_idx] <= wr_dlv;
      att_mem[wr_idx] <= wr_att;
    end
  end

  // controller arithmetic, shared across serial passes
  logic signed [8:0] e_rate;
  logic signed [17:0] err;
  logic signed [40:0] acc_full;
  logic signed [40:0] u_full;
  logic u_lt_floor, u_gt_ceil;
  logic [4:0] new_pw;
  logic signed [40:0] u_excess;
  logic signed [19:0] excess_sat;
  logic signed [39:0] d_prod;
  logic [15:0] off_sat;
  logic [7:0] sat_att, sat_dlv;
  logic [8:0] sum_att, sum_dlv;

  always_comb begin
    e_rate = $signed({2'b0, prv_r}) - $signed({2'b0, rate_q});
    err = $signed({11'b0, cfg_q.prr_target}) - ($signed({11'b0, rate_q}) + 18'(off_r));
    acc_full = $signed({20'b0, pw_r, 16'b0}) + 41'(mac_acc);
    // truncate toward zero
    u_full = (acc_full[40] && (acc_full[15:0] != 16'd0)) ?
             (acc_full >>> 16) + 41'sd1 : (acc_full >>> 16);
    u_lt_floor = u_full < $signed({36'b0, cfg_q.power_floor});
    u_gt_ceil = u_full > $signed({36'b0, cfg_q.power_ceiling});
    new_pw = u_lt_floor ? cfg_q.power_floor : (u_gt_ceil ? cfg_q.power_ceiling : u_full[4:0]);
    u_excess = u_full - $signed({36'b0, new_pw});
    // any nonzero g is at least 1, so excess beyond 2^16 already saturates the offset
    if (u_excess > 41'sd65536) excess_sat = 20'sd65536;
    else if (u_excess < -41'sd65536) excess_sat = -20'sd65536;
    else excess_sat = u_excess[19:0];
    d_prod = mac_acc;
    if (d_prod > 40'sd32767) off_sat = 16'h7fff;
    else if (d_prod < -40'sd32768) off_sat = 16'h8000;
    else off_sat = d_prod[15:0];
    sum_att = {1'b0, att_r} + {2'b0, att_in_q};
    sum_dlv = {1'b0, dlv_r} + {8'b0, dlv_in_q};
    sat_att = sum_att[8] ? 8'hff : sum_att[7:0];
    sat_dlv = sum_dlv[8] ? 8'hff : sum_dlv[7:0];
  end

  // datapath control
  always_comb begin
    state_d = state_q;
    wr_en = 1'b0;
    wr_idx = tidx;
    wr_pw = pw_r;
    wr_prv = prv_r;
    wr_off = off_r;
    wr_dlv = dlv_r;
    wr_att = att_r;
    div_req = '0;
    mac_start = 1'b0;
    mac_clear = 1'b0;
    mac_gain = cfg_q.gain_prop;
    mac_mult = 20'(e_rate);
    unique case (state_q)
      StIdle: begin
        if (start) begin
          unique case (mode_i) inside
            lptpc_pkg::ModeReport, lptpc_pkg::ModeForget: state_d = StRep;
            lptpc_pkg::ModeTick: state_d = StTRd;
            default: state_d = StIdle;
          endcase
        end
      end
      StRep: begin
        wr_idx = sidx;
        if (mode_q == lptpc_pkg::ModeReport && in_range) begin
          if (!valid_q[sidx]) begin
            wr_en = max_code;
            wr_pw = cfg_q.power_ceiling;
            wr_prv = 7'd100;
            wr_off = '0;
            wr_att = {1'b0, att_in_q};
            wr_dlv = {7'b0, dlv_in_q};
          end else if (pw_r == txp_q || (max_code && pw_r == cfg_q.power_ceiling)) begin
            wr_en = 1'b1;
            wr_att = sat_att;
            wr_dlv = sat_dlv;
          end
        end
        state_d = StIdle;
      end
      StTRd: state_d = StTChk;
      StTChk: begin
        if (valid_q[tidx] && att_r != 8'd0) begin
          div_req.start = 1'b1;
          div_req.dividend = 15'(dlv_r) * 15'd100;
          div_req.divisor = att_r;
          state_d = StDiv;
        end else begin
          state_d = StEmit;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.dividend = (div_rsp.quotient > 15'd100) ? 15'd100 : div_rsp.quotient;
          div_req.divisor = (pw_r == 5'd0) ? 8'd1 : {3'b0, pw_r};
          state_d = StGdiv;
        end
      end
      StGdiv: begin
        if (div_rsp.done) begin
          mac_clear = 1'b1;
          mac_start = 1'b1;
          state_d = StMac1;
        end
      end
      StMac1: begin
        mac_gain = cfg_q.gain_integ;
        mac_mult = 20'(err);
        if (mac_done) begin
          mac_start = 1'b1;
          state_d = StMac2;
        end
      end
      StMac2: begin
        if (mac_done) begin
          // acc now holds the full PI sum; clamp and start offset product
          wr_en = 1'b1;
          wr_pw = new_pw;
          wr_prv = rate_q;
          wr_att = '0;
          wr_dlv = '0;
          mac_clear = 1'b1;
          mac_start = 1'b1;
          mac_gain = {9'b0, g_q};
          mac_mult = excess_sat;
          state_d = StMac3;
        end
      end
      StMac3: begin
        mac_gain = {9'b0, g_q};
        mac_mult = excess_sat;
        if (mac_done) begin
          wr_en = 1'b1;
          wr_pw = pw_r;
          wr_off = off_sat;
          wr_prv = prv_r;
          wr_att = '0;
          wr_dlv = '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        state_d = (idx_q == (SW+1)'(SLOTS - 1)) ? StIdle : StTRd;
      end
      default: state_d = StIdle;
    endcase
  end

  // clamped power, held for the emit beat
  logic [4:0] npw_q;
  always_ff @(posedge clk_i) begin
    if (state_q == StMac2 && mac_done) begin
      npw_q <= new_pw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      strobe_q <= 1'b0;
      idx_q <= '0;
      upd_q <= 1'b0;
      cfg_q.prr_target <= 7'd95;
      cfg_q.gain_prop <= 16'd951;
      cfg_q.gain_integ <= 16'd1903;
      cfg_q.power_floor <= 5'd2;
      cfg_q.power_ceiling <= 5'd31;
    end else begin
      state_q <= state_d;
      strobe_q <= (state_q == StRep) || (state_q == StEmit && idx_q < (SW+1)'(NOut));
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          lptpc_pkg::RegPrrTarget: cfg_q.prr_target <= cfg_data_i[6:0];
          lptpc_pkg::RegGainProp: cfg_q.gain_prop <= cfg_data_i;
          lptpc_pkg::RegGainInteg: cfg_q.gain_integ <= cfg_data_i;
          lptpc_pkg::RegPowerFloor: cfg_q.power_floor <= cfg_data_i[4:0];
          lptpc_pkg::RegPowerCeiling: cfg_q.power_ceiling <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (state_q == StIdle && start) begin
        idx_q <= '0;
      end
      if (state_q == StRep) begin
        if (in_range) begin
          if (mode_q == lptpc_pkg::ModeForget) begin
            valid_q[sidx] <= 1'b0;
          end else if (!valid_q[sidx] && max_code) begin
            valid_q[sidx] <= 1'b1;
          end
        end
      end
      if (state_q == StTChk) begin
        upd_q <= valid_q[tidx] && att_r != 8'd0;
      end
      if (state_q == StEmit) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      mode_q <= mode_i;
      slot_q <= slot_i;
      txp_q <= tx_power_i;
      att_in_q <= attempts_i;
      dlv_in_q <= delivered_i;
    end
    if (state_q == StDiv && div_rsp.done) begin
      rate_q <= (div_rsp.quotient > 15'd100) ? 7'd100 : div_rsp.quotient[6:0];
    end
    if (state_q == StGdiv && div_rsp.done) begin
      g_q <= (pw_r == 5'd0) ? rate_q : div_rsp.quotient[6:0];
    end
    if (state_q == StRep) begin
      kind_q <= 1'b0;
      oslot_q <= slot_q;
      updq_q <= 1'b0;
      last_q <= 1'b1;
      if (mode_q == lptpc_pkg::ModeReport && in_range && (valid_q[sidx] || max_code)) begin
        known_q <= 1'b1;
        opw_q <= (valid_q[sidx]) ? (wr_en ? wr_pw : pw_r) : cfg_q.power_ceiling;
      end else begin
        known_q <= 1'b0;
        opw_q <= cfg_q.power_ceiling;
      end
    end
    if (state_q == StEmit) begin
      kind_q <= 1'b1;
      oslot_q <= 4'(idx_q);
      known_q <= valid_q[tidx];
      updq_q <= upd_q;
      last_q <= (idx_q == (SW+1)'(NOut - 1));
      opw_q <= valid_q[tidx] ? (upd_q ? npw_q : pw_r) : cfg_q.power_ceiling;
    end
  end

  assign strobe = strobe_q;
  assign kind_o = kind_q;
  assign out_slot_o = oslot_q;
  assign power_o = opw_q;
  assign slot_known_o = known_q;
  assign updated_o = updq_q;
  assign last_o = last_q;
endmodule
`default_nettype wire

### sim/link_pi_tx_power_controller_tb.sv
// testbench for link_pi_tx_power_controller: reports, forgets and control ticks
// depends on lptpc_pkg and the link_pi_tx_power_controller rtl
`timescale 1ns / 100ps
`default_nettype none
module link_pi_tx_power_controller_tb;

  localparam int unsigned NumSlots = 16;
  // mode code the block ignores
  localparam logic [1:0] ModeIdle = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [3:0] slot;
    logic [4:0] power;
    logic       known;
    logic       updated;
    logic       last;
  } power_beat_t;

  // keeps its own copy of the per-slot controller state and predicts the beats
  class link_power_scoreboard;
    int unsigned prr_target, gain_prop, gain_integ, power_floor, power_ceiling;
    bit          slot_valid[NumSlots];
    int unsigned link_power[NumSlots];
    int unsigned prev_rate[NumSlots];
    shortint     windup[NumSlots];
    int unsigned dlv_count[NumSlots];
    int unsigned att_count[NumSlots];
    power_beat_t pending[$];
    int unsigned mismatches;

    function new();
      prr_target = 95;
      gain_prop = 951;
      gain_integ = 1903;
      power_floor = 2;
      power_ceiling = 31;
      mismatches = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    function void write_reg(logic [lptpc_pkg::CfgIdxW-1:0] idx,
                            logic [lptpc_pkg::CfgDataW-1:0] data);
      case (idx)
        lptpc_pkg::RegPrrTarget:    prr_target = data[6:0];
        lptpc_pkg::RegGainProp:     gain_prop = data;
        lptpc_pkg::RegGainInteg:    gain_integ = data;
        lptpc_pkg::RegPowerFloor:   power_floor = data[4:0];
        lptpc_pkg::RegPowerCeiling: power_ceiling = data[4:0];
        default: ;
      endcase
    endfunction

    function bit is_max_code(int unsigned p);
      return p == 0 || p == 30 || p == 31;
    endfunction

    // one pi step with anti-windup on slot i
    function void run_control(int i);
      int unsigned rate;
      longint g, e, acc, u, np, d;
      rate = (dlv_count[i] * 100) / att_count[i];
      if (rate > 100) rate = 100;
      g = (link_power[i] == 0) ? rate : rate / link_power[i];
      e = longint'(prr_target) - (longint'(rate) + longint'(windup[i]));
      acc = longint'(link_power[i]) * 65536
          + longint'(gain_prop) * (longint'(prev_rate[i]) - longint'(rate))
          + longint'(gain_integ) * e;
      u = acc / 65536;  // truncates toward zero
      if (u <= longint'(power_ceiling) && u >= longint'(power_floor)) np = u;
      else if (u < longint'(power_floor)) np = power_floor;
      else np = power_ceiling;
      link_power[i] = int'(np);
      d = g * (u - np);
      if (d > 32767) d = 32767;
      if (d < -32768) d = -32768;
      windup[i] = shortint'(d);
      prev_rate[i] = rate;
      att_count[i] = 0;
      dlv_count[i] = 0;
    endfunction

    function void note_item(logic [1:0] mode, logic [3:0] s, logic [4:0] txp,
                            logic [6:0] att, logic dlv);
      power_beat_t b;
      bit upd;
      case (mode)
        lptpc_pkg::ModeReport: begin
          if (!slot_valid[s]) begin
            if (is_max_code(txp)) begin
              slot_valid[s] = 1'b1;
              link_power[s] = power_ceiling;
              prev_rate[s] = 100;
              windup[s] = 0;
              att_count[s] = att;
              dlv_count[s] = dlv;
            end
          end else if (link_power[s] == txp ||
                       (is_max_code(txp) && link_power[s] == power_ceiling)) begin
            att_count[s] = (att_count[s] + att > 255) ? 255 : att_count[s] + att;
            dlv_count[s] = (dlv_count[s] + dlv > 255) ? 255 : dlv_count[s] + dlv;
          end
          b = '{1'b0, s, slot_valid[s] ? link_power[s][4:0] : power_ceiling[4:0],
                slot_valid[s], 1'b0, 1'b1};
          pending.push_back(b);
        end
        lptpc_pkg::ModeForget: begin
          slot_valid[s] = 1'b0;
          pending.push_back('{1'b0, s, power_ceiling[4:0], 1'b0, 1'b0, 1'b1});
        end
        lptpc_pkg::ModeTick: begin
          for (int i = 0; i < NumSlots; i++) begin
            upd = slot_valid[i] && att_count[i] != 0;
            if (upd) run_control(i);
            b.kind = 1'b1;
            b.slot = 4'(i);
            b.power = slot_valid[i] ? link_power[i][4:0] : power_ceiling[4:0];
            b.known = slot_valid[i];
            b.updated = upd;
            b.last = (i == NumSlots - 1);
            pending.push_back(b);
          end
        end
        default: ;  // ignored code, no beat
      endcase
    endfunction

    function void check_result(power_beat_t act);
      power_beat_t exp_b;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: kind %0d slot %0d power %0d known %0d upd %0d last %0d",
                   act.kind, act.slot, act.power, act.known, act.updated, act.last);
        return;
      end
      exp_b = pending.pop_front();
      if (act.kind !== exp_b.kind || act.slot !== exp_b.slot ||
          act.power !== exp_b.power || act.known !== exp_b.known ||
          act.updated !== exp_b.updated || act.last !== exp_b.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp kind %0d slot %0d power %0d known %0d upd %0d last %0d",
                   exp_b.kind, exp_b.slot, exp_b.power, exp_b.known, exp_b.updated,
                   exp_b.last);
          $display("         act kind %0d slot %0d power %0d known %0d upd %0d last %0d",
                   act.kind, act.slot, act.power, act.known, act.updated, act.last);
        end
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           cfg_we_i = 1'b0;
  logic [lptpc_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [lptpc_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic [1:0]                     mode_i = '0;
  logic [3:0]                     slot_i = '0;
  logic [4:0]                     tx_power_i = '0;
  logic [6:0]                     attempts_i = '0;
  logic                           delivered_i = 1'b0;
  logic                           strobe;
  logic                           kind_o;
  logic [3:0]                     out_slot_o;
  logic [4:0]                     power_o;
  logic                           slot_known_o;
  logic                           updated_o;
  logic                           last_o;

  link_power_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  link_pi_tx_power_controller #(.SLOTS(NumSlots)) u_dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .mode_i, .slot_i, .tx_power_i, .attempts_i, .delivered_i, .strobe,
    .kind_o, .out_slot_o, .power_o, .slot_known_o, .updated_o, .last_o
  );

  // results cannot be stalled, so every strobe is checked at the edge ending it
  always @(posedge clk_i) begin
    if (rst_ni && strobe)
      sb.check_result('{kind_o, out_slot_o, power_o, slot_known_o, updated_o, last_o});
  end

  // write one register; called at a falling edge, returns at one with the enable still high
  task automatic write_reg(logic [lptpc_pkg::CfgIdxW-1:0] idx,
                           logic [lptpc_pkg::CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic write_all(int unsigned prr, int unsigned gp, int unsigned gi,
                           int unsigned fl, int unsigned ce);
    write_reg(lptpc_pkg::RegPrrTarget, lptpc_pkg::CfgDataW'(prr));
    write_reg(lptpc_pkg::RegGainProp, lptpc_pkg::CfgDataW'(gp));
    write_reg(lptpc_pkg::RegGainInteg, lptpc_pkg::CfgDataW'(gi));
    write_reg(lptpc_pkg::RegPowerFloor, lptpc_pkg::CfgDataW'(fl));
    write_reg(lptpc_pkg::RegPowerCeiling, lptpc_pkg::CfgDataW'(ce));
    cfg_we_i <= 1'b0;
  endtask

  // present one beat; start stays high afterwards, the caller lowers it for a gap
  task automatic send_item(logic [1:0] mode, logic [3:0] s, logic [4:0] txp,
                           logic [6:0] att, logic dlv);
    start <= 1'b1;
    mode_i <= mode;
    slot_i <= s;
    tx_power_i <= txp;
    attempts_i <= att;
    delivered_i <= dlv;
    // busy only moves on a rising edge, so a low value here means acceptance next edge
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    sb.note_item(mode, s, txp, att, dlv);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // drain all expected beats and wait until the block is idle, then idle on with start low
  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0 || busy) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  // mostly well-formed traffic: reports that create or hit known slots, some forgets, ticks and ignored codes
  task automatic random_item();
    int unsigned pick;
    logic [3:0] s;
    logic [4:0] txp;
    pick = $urandom_range(99);
    s = 4'($urandom);
    if (pick < 65) begin
      case ($urandom_range(3))
        0: txp = sb.slot_valid[s] ? sb.link_power[s][4:0] : 5'd31;
        1: txp = ($urandom_range(1)) ? 5'd30 : 5'd0;
        2: txp = 5'd31;
        default: txp = 5'($urandom);
      endcase
      send_item(lptpc_pkg::ModeReport, s, txp, 7'($urandom), 1'($urandom_range(3) != 0));
    end else if (pick < 75) begin
      send_item(lptpc_pkg::ModeForget, s, 5'($urandom), 7'($urandom), 1'($urandom));
    end else if (pick < 87) begin
      send_item(lptpc_pkg::ModeTick, s, 5'($urandom), 7'($urandom), 1'($urandom));
    end else if (pick < 91) begin
      send_item(ModeIdle, s, 5'($urandom), 7'($urandom), 1'($urandom));
    end else begin
      send_item(2'($urandom), s, 5'($urandom), 7'($urandom), 1'($urandom));
    end
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned burst;
    while (n > 0) begin
      burst = $urandom_range(8, 1);
      while (burst > 0 && n > 0) begin
        random_item();
        burst--;
        n--;
      end
      // some bursts run straight into the next one
      if ($urandom_range(3) != 0) idle_cycles($urandom_range(6, 1));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, reset register values
    send_item(lptpc_pkg::ModeReport, 4'd0, 5'd31, 7'd127, 1'b1);   // create on top code
    send_item(lptpc_pkg::ModeReport, 4'd0, 5'd31, 7'd127, 1'b1);   // counts on known slot
    send_item(lptpc_pkg::ModeReport, 4'd0, 5'd30, 7'd127, 1'b0);   // attempts counter saturates
    send_item(lptpc_pkg::ModeReport, 4'd1, 5'd0, 7'd1, 1'b1);      // create on zero code
    send_item(lptpc_pkg::ModeReport, 4'd2, 5'd30, 7'd3, 1'b0);     // create, nothing delivered
    send_item(lptpc_pkg::ModeReport, 4'd3, 5'd5, 7'd4, 1'b1);      // unknown, not created
    send_item(lptpc_pkg::ModeReport, 4'd0, 5'd5, 7'd9, 1'b1);      // power mismatch, ignored
    send_item(lptpc_pkg::ModeReport, 4'd15, 5'd31, 7'd0, 1'b0);    // create with no attempts
    idle_cycles(3);
    send_item(lptpc_pkg::ModeTick, 4'd0, 5'd0, 7'd0, 1'b0);
    send_item(lptpc_pkg::ModeReport, 4'd1, 5'd31, 7'd50, 1'b1);
    send_item(lptpc_pkg::ModeReport, 4'd2, 5'd0, 7'd20, 1'b1);
    send_item(lptpc_pkg::ModeForget, 4'd1, 5'd31, 7'd127, 1'b1);   // forget known slot
    send_item(lptpc_pkg::ModeForget, 4'd7, 5'd0, 7'd0, 1'b0);      // forget unknown slot
    send_item(ModeIdle, 4'd15, 5'd31, 7'd127, 1'b1);               // ignored code
    send_item(lptpc_pkg::ModeReport, 4'd1, 5'd31, 7'd127, 1'b1);   // recreate after forget
    send_item(lptpc_pkg::ModeTick, 4'd15, 5'd31, 7'd127, 1'b1);
    send_item(lptpc_pkg::ModeTick, 4'd0, 5'd0, 7'd0, 1'b0);        // no traffic since last tick
    drain();

    // register settings, extremes included; floor above ceiling once
    write_all(95, 951, 1903, 2, 31);
    random_phase(20);
    drain();
    write_all(0, 0, 0, 1, 1);
    random_phase(20);
    drain();
    write_all(100, 65535, 65535, 31, 31);
    random_phase(20);
    drain();
    write_all(60, 30000, 100, 20, 10);
    random_phase(20);
    drain();
    write_all($urandom_range(100), $urandom_range(65535), $urandom_range(65535),
              $urandom_range(12, 1), $urandom_range(31, 13));
    random_phase(20);
    drain();
    repeat (40) @(negedge clk_i);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest run
  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

### link_pi_tx_power_controller.f
design/lptpc_pkg.sv
design/lptpc_div.sv
design/lptpc_mac.sv
design/link_pi_tx_power_controller.sv
sim/link_pi_tx_power_controller_tb.sv
